// ===== rtl/core/hotp_pkg.sv =====
// Package: shared constants and types for the HOTP generate/verify engine.
`default_nettype none
package hotp_pkg;
  localparam int unsigned KEY_BYTES_MAX_DEF = 32;
  localparam int unsigned WINDOW_MAX_DEF    = 256;
  localparam int unsigned KEY_REG_BYTES     = 32;
  localparam int unsigned CODE_MOD          = 1000000;

  localparam logic [2:0] CFG_KEY_WORD_0 = 3'd0;
  localparam logic [2:0] CFG_KEY_WORD_1 = 3'd1;
  localparam logic [2:0] CFG_KEY_WORD_2 = 3'd2;
  localparam logic [2:0] CFG_KEY_WORD_3 = 3'd3;
  localparam logic [2:0] CFG_KEY_BYTES  = 3'd4;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

  typedef struct packed {
    logic start;
  } sha_ctrl_t;

  function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
    rol32 = (x << n) | (x >> (32 - n));
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/hotp_sha1.sv =====
// SHA-1 compression unit: one round per cycle over a 16-word schedule window.
`default_nettype none
module hotp_sha1
  import hotp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire sha_ctrl_t    ctrl,
  input  wire logic [511:0] block,
  input  wire logic [159:0] chain_in,
  output logic              done,
  output logic [159:0]      chain_out
);
  logic [31:0] w [16];
  logic [31:0] a, b, c, d, e;
  logic [6:0]  rnd;
  logic        busy;
  logic [31:0] f, k, tmp, wnew;

  always_comb begin
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d); k = 32'h5A827999;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d; k = 32'h6ED9EBA1;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
    end else begin
      f = b ^ c ^ d; k = 32'hCA62C1D6;
    end
    tmp  = rol32(a, 5) + f + e + k + w[0];
    wnew = rol32(w[13] ^ w[8] ^ w[2] ^ w[0], 1);
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      rnd  <= '0;
    end else if (ctrl.start) begin
      busy <= 1'b1;
      rnd  <= '0;
      for (int i = 0; i < 16; i++) w[i] <= block[511-32*i -: 32];
      {a, b, c, d, e} <= chain_in;
    end else if (busy) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wnew;
      e <= d; d <= c; c <= rol32(b, 30); b <= a; a <= tmp;
      if (rnd == 7'd79) begin
        busy <= 1'b0;
        done <= 1'b1;
        chain_out <= {chain_in[159:128] + tmp, chain_in[127:96] + a,
                      chain_in[95:64] + rol32(b, 30), chain_in[63:32] + c,
                      chain_in[31:0] + d};
      end
      rnd <= rnd + 7'd1;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/hotp_generate_verify_top.sv =====
// HOTP generate/verify engine: key registers, block sequencer and truncation.
// One code takes four SHA-1 compressions of 80 rounds on a single shared round
// unit, plus a 12-step modulo reduction and the truncate and check steps.
// Generate takes one code; verify takes one code per tried counter, up to the
// window. The block accepts one transaction at a time and is not ready until
// the result is taken.
`default_nettype none
module hotp_generate_verify_top
  import hotp_pkg::*;
#(
  parameter int unsigned KEY_BYTES_MAX = KEY_BYTES_MAX_DEF,
  parameter int unsigned WINDOW_MAX    = WINDOW_MAX_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        req_type,
  input  wire logic [63:0] start_counter,
  input  wire logic [19:0] expected_code,
  input  wire logic [8:0]  window,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [19:0]      otp_code,
  output logic             found,
  output logic [63:0]      match_counter
);
  localparam int unsigned KB_LIM = (KEY_BYTES_MAX < KEY_REG_BYTES) ? KEY_BYTES_MAX
                                                                   : KEY_REG_BYTES;
  localparam int unsigned WIN_W = $clog2(WINDOW_MAX + 1) + 1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_IPAD  = 9'b000000010,
    S_MSG1  = 9'b000000100,
    S_OPAD  = 9'b000001000,
    S_MSG2  = 9'b000010000,
    S_TRUNC = 9'b000100000,
    S_MOD   = 9'b001000000,
    S_CHECK = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t        state;
  logic [63:0]   key_word [4];
  logic [5:0]    key_bytes;
  logic          req;
  logic [63:0]   ctr;
  logic [19:0]   expect_code;
  logic [WIN_W-1:0] remain;
  logic [159:0]  chain, inner_dig;
  logic [31:0]   rem;
  logic [5:0]    mstep;
  sha_ctrl_t     sctrl;
  logic [511:0]  blk;
  logic          sdone;
  logic [159:0]  sout;
  logic [511:0]  key_blk;
  logic [5:0]    kb_eff;
  logic [159:0]  chain_sel;
  logic [WIN_W-1:0] win_sat;

  always_comb begin
    kb_eff = (key_bytes > 6'(KB_LIM)) ? 6'(KB_LIM) : key_bytes;
    key_blk = '0;
    for (int i = 0; i < 32; i++)
      if (i < kb_eff) key_blk[511-8*i -: 8] = key_word[i/8][63-8*(i%8) -: 8];
    win_sat = (32'(window) > WINDOW_MAX) ? WIN_W'(WINDOW_MAX) : WIN_W'(window);
  end

  always_comb begin
    case (state)
      S_IPAD:  blk = key_blk ^ {64{8'h36}};
      S_OPAD:  blk = key_blk ^ {64{8'h5C}};
      S_MSG1:  blk = {ctr, 8'h80, 376'b0, 64'd576};
      S_MSG2:  blk = {inner_dig, 8'h80, 280'b0, 64'd672};
      default: blk = '0;
    endcase
    chain_sel = (state == S_IPAD || state == S_OPAD) ?
                {H0_INIT, H1_INIT, H2_INIT, H3_INIT, H4_INIT} : chain;
  end

  hotp_sha1 u_sha1 (
    .clk(clk), .rst(rst), .ctrl(sctrl), .block(blk), .chain_in(chain_sel),
    .done(sdone), .chain_out(sout)
  );

  logic [3:0]  off;
  logic [31:0] trunc;
  logic [32:0] trial;
  always_comb begin
    off   = sout[3:0];
    trunc = sout[159 - 8*off -: 32] & 32'h7FFFFFFF;
    trial = {1'b0, rem} - {1'b0, 32'(CODE_MOD) << mstep[4:0]};
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    sctrl.start <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      key_word[0] <= '0; key_word[1] <= '0; key_word[2] <= '0; key_word[3] <= '0;
      key_bytes <= 6'd32;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEY_WORD_0: key_word[0] <= cfg_data;
          CFG_KEY_WORD_1: key_word[1] <= cfg_data;
          CFG_KEY_WORD_2: key_word[2] <= cfg_data;
          CFG_KEY_WORD_3: key_word[3] <= cfg_data;
          CFG_KEY_BYTES:  key_bytes <= cfg_data[5:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: if (in_valid) begin
          req <= req_type; ctr <= start_counter;
          expect_code <= expected_code;
          remain <= req_type ? win_sat : WIN_W'(1);
          if (req_type && win_sat == '0) begin
            otp_code <= '0; found <= 1'b0; match_counter <= '0;
            state <= S_OUT;
          end else begin
            state <= S_IPAD; sctrl.start <= 1'b1;
          end
        end
        S_IPAD: if (sdone) begin
          chain <= sout; state <= S_MSG1; sctrl.start <= 1'b1;
        end
        S_MSG1: if (sdone) begin
          inner_dig <= sout; state <= S_OPAD; sctrl.start <= 1'b1;
        end
        S_OPAD: if (sdone) begin
          chain <= sout; state <= S_MSG2; sctrl.start <= 1'b1;
        end
        S_MSG2: if (sdone) state <= S_TRUNC;
        S_TRUNC: begin
          rem <= trunc; mstep <= 6'd11; state <= S_MOD;
        end
        S_MOD: begin
          if (!trial[32]) rem <= trial[31:0];
          if (mstep == '0) state <= S_CHECK;
          else mstep <= mstep - 6'd1;
        end
        S_CHECK: begin
          if (!req || rem[19:0] == expect_code && rem[31:20] == '0) begin
            otp_code <= rem[19:0]; found <= 1'b1; match_counter <= ctr;
            state <= S_OUT;
          end else if (remain == WIN_W'(1)) begin
            otp_code <= '0; found <= 1'b0; match_counter <= '0;
            state <= S_OUT;
          end else begin
            remain <= remain - WIN_W'(1); ctr <= ctr + 64'd1;
            state <= S_IPAD; sctrl.start <= 1'b1;
          end
        end
        S_OUT: if (out_ready) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
